@@ rtl/core/cds_pkg.sv @@
`timescale 1ns / 1ps

package cds_pkg;

  // Field widths
  localparam int unsigned YearW  = 14;
  localparam int unsigned MonthW = 4;
  localparam int unsigned DayW   = 5;
  localparam int unsigned WdayW  = 3;

  // Beat widths, padded to whole bytes
  localparam int unsigned InDataW  = 24;
  localparam int unsigned OutDataW = 40;

  localparam logic [YearW-1:0]  YearMax = 14'd9999;
  localparam logic [MonthW-1:0] MonthJan = 4'd1;
  localparam logic [MonthW-1:0] MonthFeb = 4'd2;
  localparam logic [MonthW-1:0] MonthDec = 4'd12;
  localparam logic [DayW-1:0]   DayLast  = 5'd31;

  // Step direction carried on the input tuser
  typedef enum logic {
    KIND_NEXT = 1'b0,
    KIND_PREV = 1'b1
  } kind_e;

  // floor(v / 100) for v < 16800: multiply by 5243 / 2^19
  localparam logic [12:0] RecipDiv100 = 13'd5243;
  // floor(x / 7) for x < 256: multiply by 293 / 2^11
  localparam logic [8:0]  RecipDiv7   = 9'd293;

  function automatic logic [7:0] div100(input logic [14:0] v);
    logic [27:0] p;
    p = 28'(v) * 28'(RecipDiv100);
    return p[26:19];
  endfunction

  function automatic logic [2:0] mod7(input logic [7:0] x);
    logic [16:0] p;
    logic [5:0]  q;
    logic [7:0]  r;
    p = 17'(x) * 17'(RecipDiv7);
    q = p[16:11];
    r = x - 8'(q) * 8'd7;
    return r[2:0];
  endfunction

  // Days in a month; zero for a month code outside 1..12
  function automatic logic [DayW-1:0] month_days(input logic [MonthW-1:0] m,
                                                 input logic leap);
    logic [DayW-1:0] len;
    unique case (m) inside
      4'd2:                                   len = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:                len = 5'd30;
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
      default:                                len = '0;
    endcase
    return len;
  endfunction

  // Gauss month term floor(2.6*sm - 0.2), sm counted from March
  function automatic logic [DayW-1:0] month_term(input logic [MonthW-1:0] m);
    logic [DayW-1:0] t;
    unique case (m)
      4'd3:    t = 5'd2;
      4'd4:    t = 5'd5;
      4'd5:    t = 5'd7;
      4'd6:    t = 5'd10;
      4'd7:    t = 5'd12;
      4'd8:    t = 5'd15;
      4'd9:    t = 5'd18;
      4'd10:   t = 5'd20;
      4'd11:   t = 5'd23;
      4'd12:   t = 5'd25;
      4'd1:    t = 5'd28;
      4'd2:    t = 5'd31;
      default: t = '0;
    endcase
    return t;
  endfunction

endpackage

@@ rtl/core/calendar_date_step.sv @@
`timescale 1ns / 1ps
// A beat goes from the input register to the result register on the master side.
// Throughput: one beat per cycle; an input register feeds a result register
// through one pass of date logic, and both stages move whenever the next is free.
// Reset: asynchronous, active low; it empties both stages, no other state is kept.

module calendar_date_step
  import cds_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  // tdata: year_in[13:0], month_in[17:14], day_in[22:18], zeros above
  input  logic [InDataW-1:0]  s_axis_tdata,
  // tuser: kind (0 next day, 1 previous day)
  input  logic                s_axis_tuser,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // tdata: date_valid[0], leap_year[1], month_length[6:2], weekday[9:7],
  //        year_out[23:10], month_out[27:24], day_out[32:28], at_limit[33],
  //        zeros above
  output logic [OutDataW-1:0] m_axis_tdata,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready
);

  // Input stage
  logic              in_vld_q;
  kind_e             kind_q;
  logic [YearW-1:0]  year_q;
  logic [MonthW-1:0] month_q;
  logic [DayW-1:0]   day_q;

  // Result stage
  logic              out_vld_q;
  logic              valid_q, leap_q, limit_q;
  logic [DayW-1:0]   len_q, day_out_q;
  logic [WdayW-1:0]  wday_q;
  logic [YearW-1:0]  year_out_q;
  logic [MonthW-1:0] month_out_q;

  logic              valid_d, leap_d, limit_d;
  logic [DayW-1:0]   len_d, day_out_d;
  logic [WdayW-1:0]  wday_d;
  logic [YearW-1:0]  year_out_d;
  logic [MonthW-1:0] month_out_d;

  logic out_adv;
  logic in_take;

  assign out_adv       = !out_vld_q || m_axis_tready;
  assign s_axis_tready = !in_vld_q || out_adv;
  assign in_take       = s_axis_tvalid && s_axis_tready;

  // Pipeline valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (s_axis_tready) in_vld_q <= s_axis_tvalid;
      if (out_adv)       out_vld_q <= in_vld_q;
    end
  end

  // Input payload
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      kind_q  <= kind_e'(s_axis_tuser);
      year_q  <= s_axis_tdata[13:0];
      month_q <= s_axis_tdata[17:14];
      day_q   <= s_axis_tdata[22:18];
    end
  end

  // Leap year from floor(y/100) and y mod 100
  logic [7:0]  yq100;
  logic [6:0]  yr100;
  always_comb begin
    yq100  = div100({1'b0, year_q});
    yr100  = 7'(year_q - 14'(yq100) * 14'd100);
    leap_d = (yr100 == '0) ? (yq100[1:0] == 2'd0) : (yr100[1:0] == 2'd0);
  end

  // Month length and date check
  always_comb begin
    len_d   = month_days(month_q, leap_d);
    valid_d = (len_d != '0) && (day_q != '0) && (day_q <= len_d);
  end

  // Weekday: Jan/Feb count in the year before; only the year mod 400 matters
  logic [14:0] wy;
  logic [7:0]  wq100;
  logic [6:0]  wr100;
  logic [7:0]  wsum;
  always_comb begin
    wy    = ((month_q == MonthJan) || (month_q == MonthFeb)) ?
            (15'(year_q) + 15'd399) : 15'(year_q);
    wq100 = div100(wy);
    wr100 = 7'(wy - 15'(wq100) * 15'd100);
    // day + month term + (y%4) + 5*((y%100)/4) + 5*((y%400)/100), all mod 7
    wsum  = 8'(day_q) + 8'(month_term(month_q)) + 8'(wr100[1:0])
          + 8'(wr100[6:2]) * 8'd5 + 8'(wq100[1:0]) * 8'd5;
    wday_d = valid_d ? mod7(wsum) : '0;
  end

  // Day step with month and year rollover, held at the year range ends
  always_comb begin
    year_out_d  = year_q;
    month_out_d = month_q;
    day_out_d   = day_q;
    limit_d     = 1'b0;
    if (valid_d) begin
      if (year_q > YearMax) begin
        limit_d = 1'b1;
      end else if (kind_q == KIND_NEXT) begin
        if (day_q < len_d) begin
          day_out_d = day_q + 5'd1;
        end else if (month_q < MonthDec) begin
          month_out_d = month_q + 4'd1;
          day_out_d   = 5'd1;
        end else if (year_q < YearMax) begin
          year_out_d  = year_q + 14'd1;
          month_out_d = MonthJan;
          day_out_d   = 5'd1;
        end else begin
          limit_d = 1'b1;
        end
      end else begin
        if (day_q > 5'd1) begin
          day_out_d = day_q - 5'd1;
        end else if (month_q > MonthJan) begin
          month_out_d = month_q - 4'd1;
          day_out_d   = month_days(month_q - 4'd1, leap_d);
        end else if (year_q != '0) begin
          year_out_d  = year_q - 14'd1;
          month_out_d = MonthDec;
          day_out_d   = DayLast;
        end else begin
          limit_d = 1'b1;
        end
      end
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    if (out_adv && in_vld_q) begin
      valid_q     <= valid_d;
      leap_q      <= leap_d;
      len_q       <= len_d;
      wday_q      <= wday_d;
      year_out_q  <= year_out_d;
      month_out_q <= month_out_d;
      day_out_q   <= day_out_d;
      limit_q     <= limit_d;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {6'd0, limit_q, day_out_q, month_out_q, year_out_q,
                          wday_q, len_q, leap_q, valid_q};

endmodule
